[src/mca_pkg.sv]
// shared constants, codes and sequencer state type for the motion command arbiter
package mca_pkg;

  localparam int NUM_SOURCES_DEF     = 5;
  localparam int ANGULAR_EPSILON_DEF = 1;
  localparam int SPEED_WIDTH_DEF     = 16;

  // per-source timeout registers; sources past the last one share it
  localparam int NUM_TIMEOUT_REGS = 5;

  // width of the shared subtractor, covers 32-bit speeds and times with sign
  localparam int UNIT_W = 34;

  localparam logic [3:0] CMD_SET         = 4'd0;
  localparam logic [3:0] CMD_SET_FOR_GEN = 4'd1;
  localparam logic [3:0] CMD_GET         = 4'd2;
  localparam logic [3:0] CMD_CLEAR_ALL   = 4'd3;
  localparam logic [3:0] CMD_CLEAR_SRC   = 4'd4;
  localparam logic [3:0] CMD_BEGIN_MAINT = 4'd5;
  localparam logic [3:0] CMD_END_MAINT   = 4'd6;
  localparam logic [3:0] CMD_EMERGENCY   = 4'd7;
  localparam logic [3:0] CMD_FAULT       = 4'd8;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REJECT  = 2'd1;
  localparam logic [1:0] STATUS_STOPPED = 2'd2;

  localparam logic [2:0] REG_MAX_LINEAR    = 3'd5;
  localparam logic [2:0] REG_MAX_ANGULAR   = 3'd6;
  localparam logic [2:0] REG_KINEMATICS_OK = 3'd7;

  localparam logic [15:0] TIMEOUT_RESET     = 16'd500;
  localparam logic [14:0] MAX_LINEAR_RESET  = 15'd1000;
  localparam logic [14:0] MAX_ANGULAR_RESET = 15'd3000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LIN_HI,
    ST_LIN_LO,
    ST_ANG_HI,
    ST_ANG_LO,
    ST_STORE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

[src/motion_command_arbiter_unit.sv]
// motion command arbiter: per-source velocity slots, stop latches and a shared subtract unit
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       s_tuser command, s_tdata command fields
// m_*       out  m_tvalid / m_tready       m_tdata result fields
// apb       in   psel & penable & pwrite   paddr register byte address, pwdata / prdata
//
// a set that passes its checks runs CHECK, LIN_HI, LIN_LO, ANG_HI, ANG_LO and STORE (two
// compares per speed clamp on the subtractor), a rejected or stopped set only CHECK; a get
// scans k slots, one slot per cycle (k is 0 while a latch is set, else 1..NUM_SOURCES);
// every other command runs only CHECK. Each then ends in DONE. s_tready is high only while the
// sequencer is idle and rst is low.
// a finished result sits in the output register while the next word is taken in;
// the sequencer waits in its last state while m_tready holds it off.
// rst is synchronous: slots disabled, latches and generation zero, registers to defaults.
module motion_command_arbiter_unit
  import mca_pkg::*;
#(
  parameter int NUM_SOURCES     = NUM_SOURCES_DEF,
  parameter int ANGULAR_EPSILON = ANGULAR_EPSILON_DEF,
  parameter int SPEED_WIDTH     = SPEED_WIDTH_DEF,
  localparam int IN_W   = 102 + 2 * SPEED_WIDTH,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = 73 + 2 * SPEED_WIDTH,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // source[2:0], enable, lin_req, ang_req, non_finite, set_stamp[31:0],
  // want_gen[31:0], now_ms[31:0], stop_enable, zero fill
  input  logic [IN_TW-1:0]  s_tdata,
  // command[3:0]
  input  logic [3:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // status[1:0], have_command, active_source[2:0], out_linear, out_angular,
  // out_timestamp[31:0], emergency_active, fault_active, maintenance_active,
  // generation[31:0], zero fill
  output logic [OUT_TW-1:0] m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int W   = SPEED_WIDTH;
  localparam int SIW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  // configuration registers
  logic [15:0] timeout_reg [NUM_TIMEOUT_REGS];
  logic [14:0] max_linear;
  logic [14:0] max_angular;
  logic        kinematics_ok;

  // slots
  logic                slot_enable  [NUM_SOURCES];
  logic signed [W-1:0] slot_linear  [NUM_SOURCES];
  logic signed [W-1:0] slot_angular [NUM_SOURCES];
  logic [31:0]         slot_time    [NUM_SOURCES];

  logic        emergency_latch;
  logic        fault_latch;
  logic        maintenance_latch;
  logic [31:0] revoke_generation;

  // held command word
  logic [3:0]          cmd;
  logic [2:0]          src;
  logic                enable;
  logic signed [W-1:0] lin_in;
  logic signed [W-1:0] ang_in;
  logic                non_finite;
  logic [31:0]         set_stamp;
  logic [31:0]         want_gen;
  logic [31:0]         now_ms;
  logic                stop_enable;

  // working results
  logic signed [W-1:0] lin_c;
  logic signed [W-1:0] ang_c;
  logic [1:0]          res_status;
  logic                res_have;
  logic [2:0]          res_act;
  logic signed [W-1:0] res_lin;
  logic signed [W-1:0] res_ang;
  logic [31:0]         res_ts;
  logic [SIW-1:0]      scan_idx;

  state_t state, state_next;

  // shared subtract unit
  logic signed [UNIT_W-1:0] unit_a, unit_b, unit_diff;
  logic                     unit_pos, unit_neg;

  // decode
  logic           any_latch;
  logic           src_valid;
  logic [SIW-1:0] src_idx;
  logic           set_reject;
  logic           set_stop;
  logic           is_set;
  logic [3:0]     tidx_wide;
  logic [2:0]     tsel;
  logic           scan_hit;
  logic           scan_last;
  logic           out_free;
  logic           turn_block;
  logic [W:0]     ang_mag;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE) && !rst;
  assign cfg_idx  = paddr[4:2];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !m_tvalid || m_tready;

  assign any_latch = emergency_latch || fault_latch || maintenance_latch;
  assign src_valid = (src != 3'd0) && ({1'b0, src} <= 4'(NUM_SOURCES));
  assign src_idx   = SIW'(src - 3'd1);
  assign is_set    = (cmd == CMD_SET) || (cmd == CMD_SET_FOR_GEN);
  assign set_reject = any_latch
                   || ((cmd == CMD_SET_FOR_GEN) && (revoke_generation != want_gen))
                   || !src_valid;
  assign set_stop  = non_finite || !enable;

  assign unit_diff = unit_a - unit_b;
  assign unit_neg  = unit_diff[UNIT_W-1];
  assign unit_pos  = !unit_diff[UNIT_W-1] && (unit_diff != '0);

  // timeout of the slot under scan
  assign tidx_wide = 4'(scan_idx);
  assign tsel      = (tidx_wide < 4'(NUM_TIMEOUT_REGS)) ? tidx_wide[2:0]
                                                        : 3'(NUM_TIMEOUT_REGS - 1);
  assign scan_hit  = slot_enable[scan_idx]
                  && (unit_diff[31:0] <= {16'd0, timeout_reg[tsel]});
  assign scan_last = ({1'b0, tidx_wide} == 5'(NUM_SOURCES - 1));

  assign ang_mag    = ang_c[W-1] ? -{ang_c[W-1], ang_c} : {ang_c[W-1], ang_c};
  assign turn_block = !kinematics_ok
                   && (UNIT_W'(ang_mag) > UNIT_W'(ANGULAR_EPSILON));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (is_set) begin
          state_next = (set_reject || set_stop) ? ST_DONE : ST_LIN_HI;
        end else if (cmd == CMD_GET) begin
          state_next = any_latch ? ST_DONE : ST_SCAN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_LIN_HI: state_next = ST_LIN_LO;
      ST_LIN_LO: state_next = ST_ANG_HI;
      ST_ANG_HI: state_next = ST_ANG_LO;
      ST_ANG_LO: state_next = ST_STORE;
      ST_STORE:  state_next = ST_DONE;
      ST_SCAN: begin
        if (scan_hit || scan_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // subtractor operands per step
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state)
      ST_CHECK: begin
        // generation increment as gen - (-1)
        unit_a = $signed({2'b00, revoke_generation});
        unit_b = '1;
      end
      ST_LIN_HI: begin
        unit_a = UNIT_W'(lin_in);
        unit_b = $signed({{(UNIT_W-15){1'b0}}, max_linear});
      end
      ST_LIN_LO: begin
        unit_a = UNIT_W'(lin_in);
        unit_b = -$signed({{(UNIT_W-15){1'b0}}, max_linear});
      end
      ST_ANG_HI: begin
        unit_a = UNIT_W'(ang_in);
        unit_b = $signed({{(UNIT_W-15){1'b0}}, max_angular});
      end
      ST_ANG_LO: begin
        unit_a = UNIT_W'(ang_in);
        unit_b = -$signed({{(UNIT_W-15){1'b0}}, max_angular});
      end
      ST_SCAN: begin
        // age = now - stamp, mod 2^32 in the low bits
        unit_a = $signed({2'b00, now_ms});
        unit_b = $signed({2'b00, slot_time[scan_idx]});
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMEOUT_REGS; i++) timeout_reg[i] <= TIMEOUT_RESET;
      max_linear    <= MAX_LINEAR_RESET;
      max_angular   <= MAX_ANGULAR_RESET;
      kinematics_ok <= 1'b1;
    end else if (cfg_wr) begin
      if ({1'b0, cfg_idx} < 4'(NUM_TIMEOUT_REGS)) begin
        timeout_reg[cfg_idx] <= pwdata[15:0];
      end else if (cfg_idx == REG_MAX_LINEAR) begin
        max_linear <= pwdata[14:0];
      end else if (cfg_idx == REG_MAX_ANGULAR) begin
        max_angular <= pwdata[14:0];
      end else if (cfg_idx == REG_KINEMATICS_OK) begin
        kinematics_ok <= pwdata[0];
      end
    end
  end

  always_comb begin
    if ({1'b0, cfg_idx} < 4'(NUM_TIMEOUT_REGS)) begin
      prdata = {16'd0, timeout_reg[cfg_idx]};
    end else if (cfg_idx == REG_MAX_LINEAR) begin
      prdata = {17'd0, max_linear};
    end else if (cfg_idx == REG_MAX_ANGULAR) begin
      prdata = {17'd0, max_angular};
    end else begin
      prdata = {31'd0, kinematics_ok};
    end
  end

  // input capture and working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      cmd         <= s_tuser;
      src         <= s_tdata[2:0];
      enable      <= s_tdata[3];
      lin_in      <= $signed(s_tdata[4 +: W]);
      ang_in      <= $signed(s_tdata[4 + W +: W]);
      non_finite  <= s_tdata[4 + 2 * W];
      set_stamp   <= s_tdata[5 + 2 * W +: 32];
      want_gen    <= s_tdata[37 + 2 * W +: 32];
      now_ms      <= s_tdata[69 + 2 * W +: 32];
      stop_enable <= s_tdata[101 + 2 * W];
      res_status  <= STATUS_OK;
      res_have    <= 1'b0;
      res_act     <= 3'd0;
      res_lin     <= '0;
      res_ang     <= '0;
      res_ts      <= 32'd0;
      scan_idx    <= '0;
    end
    case (state)
      ST_CHECK: begin
        if (is_set) begin
          if (set_reject) res_status <= STATUS_REJECT;
          else if (set_stop) res_status <= STATUS_STOPPED;
        end else if (cmd == CMD_BEGIN_MAINT) begin
          if (maintenance_latch) res_status <= STATUS_REJECT;
        end else if (cmd != CMD_GET && cmd != CMD_CLEAR_ALL && cmd != CMD_CLEAR_SRC
                     && cmd != CMD_END_MAINT && cmd != CMD_EMERGENCY
                     && cmd != CMD_FAULT) begin
          res_status <= STATUS_REJECT;
        end
      end
      ST_LIN_HI: lin_c <= unit_pos ? W'(max_linear) : lin_in;
      ST_LIN_LO: begin
        if (unit_neg) lin_c <= W'(unit_b);
      end
      ST_ANG_HI: ang_c <= unit_pos ? W'(max_angular) : ang_in;
      ST_ANG_LO: begin
        if (unit_neg) ang_c <= W'(unit_b);
      end
      ST_STORE: begin
        if (turn_block) res_status <= STATUS_STOPPED;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          res_have <= 1'b1;
          res_act  <= 3'(tidx_wide + 4'd1);
          res_lin  <= slot_linear[scan_idx];
          res_ang  <= slot_angular[scan_idx];
          res_ts   <= slot_time[scan_idx];
        end else if (!scan_last) begin
          scan_idx <= scan_idx + SIW'(1);
        end
      end
      default: ;
    endcase
  end

  // slots, latches and generation
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SOURCES; i++) slot_enable[i] <= 1'b0;
      emergency_latch   <= 1'b0;
      fault_latch       <= 1'b0;
      maintenance_latch <= 1'b0;
      revoke_generation <= 32'd0;
    end else begin
      case (state)
        ST_CHECK: begin
          case (cmd)
            CMD_SET, CMD_SET_FOR_GEN: begin
              if (!set_reject && set_stop) slot_enable[src_idx] <= 1'b0;
            end
            CMD_CLEAR_ALL: begin
              for (int i = 0; i < NUM_SOURCES; i++) slot_enable[i] <= 1'b0;
            end
            CMD_CLEAR_SRC: begin
              if (src_valid) slot_enable[src_idx] <= 1'b0;
            end
            CMD_BEGIN_MAINT: begin
              if (!maintenance_latch) begin
                maintenance_latch <= 1'b1;
                revoke_generation <= unit_diff[31:0];
                for (int i = 0; i < NUM_SOURCES; i++) slot_enable[i] <= 1'b0;
              end
            end
            CMD_END_MAINT: maintenance_latch <= 1'b0;
            CMD_EMERGENCY: begin
              if (stop_enable && !emergency_latch) revoke_generation <= unit_diff[31:0];
              emergency_latch <= stop_enable;
              for (int i = 0; i < NUM_SOURCES; i++) slot_enable[i] <= 1'b0;
            end
            CMD_FAULT: begin
              if (stop_enable && !fault_latch) revoke_generation <= unit_diff[31:0];
              fault_latch <= stop_enable;
              for (int i = 0; i < NUM_SOURCES; i++) slot_enable[i] <= 1'b0;
            end
            default: ;
          endcase
        end
        ST_STORE: begin
          slot_enable[src_idx] <= !turn_block;
        end
        default: ;
      endcase
    end
  end

  // slot payload, only meaningful while the slot is enabled
  always_ff @(posedge clk) begin
    if (state == ST_STORE && !turn_block) begin
      slot_linear[src_idx]  <= lin_c;
      slot_angular[src_idx] <= ang_c;
      slot_time[src_idx]    <= set_stamp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {{(OUT_TW - OUT_W){1'b0}}, revoke_generation, maintenance_latch,
                  fault_latch, emergency_latch, res_ts, res_ang, res_lin, res_act,
                  res_have, res_status};
    end
  end

endmodule
